@@ rtl/lpr_pkg.sv @@
// lpr_pkg: shared types, constants and helper functions of the line pixel rasterizer
// holds the microcode table of the walk sequencer and the coordinate saturate/clamp functions
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

    localparam int GRID_SIZE = 8;
    localparam int COORD_W   = 5;
    localparam int ERR_W     = 7;
    localparam int PIX_W     = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [COORD_W-1:0] span_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic        [PIX_W-1:0]   pix_t;

    localparam coord_t COORD_LOW = coord_t'(-8);

    // microcode step addresses
    typedef logic [1:0] step_t;
    localparam step_t STEP_IDLE  = 2'd0;
    localparam step_t STEP_SETUP = 2'd1;
    localparam step_t STEP_WALK  = 2'd2;
    localparam step_t STEP_SPARE = 2'd3;

    typedef enum logic [1:0] {
        JC_NONE   = 2'd0,
        JC_ALWAYS = 2'd1,
        JC_AT_END = 2'd2
    } jump_cond_t;

    typedef struct packed {
        logic       wait_in;    // hold until an input word arrives
        logic       load_ends;  // capture start and end points
        logic       setup;      // spans, directions, initial error
        logic       walk;       // emit current point and step, held by output stall
        jump_cond_t jcond;
        step_t      target;
        logic       hold_step;  // stay on this step when no jump is taken
    } ctrl_word_t;

    function automatic ctrl_word_t ucode_rom(input step_t addr);
        ctrl_word_t cw;
        cw = '{wait_in: 1'b0, load_ends: 1'b0, setup: 1'b0, walk: 1'b0,
               jcond: JC_NONE, target: STEP_IDLE, hold_step: 1'b0};
        unique case (addr)
            STEP_IDLE: begin
                cw.wait_in   = 1'b1;
                cw.load_ends = 1'b1;
            end
            STEP_SETUP: begin
                cw.setup = 1'b1;
            end
            STEP_WALK: begin
                cw.walk      = 1'b1;
                cw.jcond     = JC_AT_END;
                cw.target    = STEP_IDLE;
                cw.hold_step = 1'b1;
            end
            default: begin
                cw.jcond  = JC_ALWAYS;
                cw.target = STEP_IDLE;
            end
        endcase
        return cw;
    endfunction

    // raw field below -8 saturates to -8
    function automatic coord_t coord_sat(input logic [COORD_W-1:0] raw);
        coord_t v;
        v = coord_t'(raw);
        if (v < COORD_LOW) begin
            v = COORD_LOW;
        end
        return v;
    endfunction

    // clamp a walk coordinate onto the grid, then fit the output field
    function automatic pix_t grid_clamp(input coord_t v);
        logic signed [COORD_W:0] w;
        logic signed [COORD_W:0] top;
        w   = (COORD_W+1)'(v);
        top = (COORD_W+1)'(GRID_SIZE - 1);
        if (w < 0) begin
            w = '0;
        end
        if (w > top) begin
            w = top;
        end
        return w[PIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/line_pixel_rasterizer.sv @@
// line_pixel_rasterizer: walks an error-term line start to end, one pixel a cycle unless stalled
// depends on lpr_pkg (microcode table, coordinate types, saturate and clamp functions)
//
// Usage:
//   s_ channel: one word per line segment; s_tdata holds start_x, start_y, end_x, end_y
//   (5-bit two's complement each). s_tready is high only while the sequencer sits on its
//   idle step, so one segment is processed at a time.
//   m_ channel: one word per visited point, start and end included; m_tdata holds
//   pixel_x and pixel_y clamped onto the grid, m_tlast marks the end point.
//   Timing: after a segment is accepted, the setup step follows, then the walk step loads
//   one pixel per cycle into the output register while that register is free; the first
//   pixel shows on m_tvalid once the walk step has registered it. A line of N points
//   passes through idle, setup and one walk step per point, 24 points at most for the
//   longest line. The single walk microstep emits and advances the point together.
//   Stall: when m_tready is low with a pixel waiting, the walk step holds its point and
//   error term until the output register frees. The last pixel may still wait while the
//   next segment is accepted.
//   Reset: aresetn low returns the sequencer to the idle step and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_rasterizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // start_x[4:0], start_y[9:5], end_x[14:10], end_y[19:15]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // pixel_x[2:0], pixel_y[5:3]
    output logic             m_tlast    // last_pixel
);
    import lpr_pkg::*;

    step_t      pc_reg, pc_next;
    ctrl_word_t cw;

    coord_t walk_x_reg, walk_x_next;
    coord_t walk_y_reg, walk_y_next;
    coord_t target_x_reg, target_y_reg;
    span_t  span_x_reg, span_y_reg;
    logic   dir_x_neg_reg, dir_y_neg_reg;
    err_t   err_reg, err_next;

    logic   m_tvalid_reg;
    pix_t   pix_x_reg, pix_y_reg;
    logic   last_reg;

    logic   at_end;
    logic   out_free;
    logic   go;
    logic   jump_taken;
    logic   emit;

    logic signed [COORD_W:0] diff_x, diff_y;
    logic signed [ERR_W:0]   doubled;
    logic signed [ERR_W:0]   sx_ext, sy_ext;
    logic                    step_x, step_y;
    logic signed [ERR_W:0]   err_sum;

    assign cw       = ucode_rom(pc_reg);
    assign at_end   = (walk_x_reg == target_x_reg) && (walk_y_reg == target_y_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = cw.wait_in;
    assign emit     = cw.walk && out_free;

    always_comb begin
        unique case (cw.wait_in)
            1'b1:    go = s_tvalid;
            default: go = cw.walk ? out_free : 1'b1;
        endcase
    end

    always_comb begin
        case (cw.jcond)
            JC_ALWAYS: jump_taken = 1'b1;
            JC_AT_END: jump_taken = at_end;
            default:   jump_taken = 1'b0;
        endcase
    end

    always_comb begin
        if (!go) begin
            pc_next = pc_reg;
        end else if (jump_taken) begin
            pc_next = cw.target;
        end else if (cw.hold_step) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + step_t'(1);
        end
    end

    // datapath: spans and directions
    assign diff_x = (COORD_W+1)'(target_x_reg) - (COORD_W+1)'(walk_x_reg);
    assign diff_y = (COORD_W+1)'(target_y_reg) - (COORD_W+1)'(walk_y_reg);

    // error-term step
    assign doubled = (ERR_W+1)'(err_reg) <<< 1;
    assign sx_ext  = (ERR_W+1)'({1'b0, span_x_reg});
    assign sy_ext  = (ERR_W+1)'({1'b0, span_y_reg});
    assign step_x  = doubled > -sy_ext;
    assign step_y  = doubled < sx_ext;
    assign err_sum = (ERR_W+1)'(err_reg) - (step_x ? sy_ext : '0) + (step_y ? sx_ext : '0);

    always_comb begin
        walk_x_next = walk_x_reg;
        walk_y_next = walk_y_reg;
        err_next    = err_reg;
        if (cw.setup) begin
            err_next = ERR_W'((ERR_W+1)'({1'b0, diff_x < 0 ? span_t'(-diff_x) : span_t'(diff_x)})
                            - (ERR_W+1)'({1'b0, diff_y < 0 ? span_t'(-diff_y)
                                                            : span_t'(diff_y)}));
        end else if (emit && !at_end) begin
            err_next = err_sum[ERR_W-1:0];
            if (step_x) begin
                walk_x_next = dir_x_neg_reg ? walk_x_reg - coord_t'(1)
                                            : walk_x_reg + coord_t'(1);
            end
            if (step_y) begin
                walk_y_next = dir_y_neg_reg ? walk_y_reg - coord_t'(1)
                                            : walk_y_reg + coord_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= STEP_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cw.load_ends && s_tvalid) begin
            walk_x_reg   <= coord_sat(s_tdata[4:0]);
            walk_y_reg   <= coord_sat(s_tdata[9:5]);
            target_x_reg <= coord_sat(s_tdata[14:10]);
            target_y_reg <= coord_sat(s_tdata[19:15]);
        end else begin
            walk_x_reg <= walk_x_next;
            walk_y_reg <= walk_y_next;
        end
        err_reg <= err_next;
        if (cw.setup) begin
            span_x_reg    <= diff_x < 0 ? span_t'(-diff_x) : span_t'(diff_x);
            span_y_reg    <= diff_y < 0 ? span_t'(-diff_y) : span_t'(diff_y);
            dir_x_neg_reg <= !(diff_x > 0);
            dir_y_neg_reg <= !(diff_y > 0);
        end
        if (emit) begin
            pix_x_reg <= grid_clamp(walk_x_reg);
            pix_y_reg <= grid_clamp(walk_y_reg);
            last_reg  <= at_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, pix_y_reg, pix_x_reg};
    assign m_tlast  = last_reg;

    // a segment is accepted only on the idle step and always moves on to setup
    a_accept_to_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (pc_reg == STEP_SETUP))
        else $error("accepted segment did not move to setup");

    // emitting the end point returns the sequencer to idle
    a_end_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && at_end) |=> (pc_reg == STEP_IDLE))
        else $error("end point emitted but sequencer not idle");

    // any pixel still waiting during setup belongs to the previous line's end
    a_setup_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == STEP_SETUP) |-> (!m_tvalid_reg || last_reg))
        else $error("non-final pixel pending across line boundary");

    // the walk never moves farther from the end point than the line's span
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == STEP_WALK) |->
            ((diff_x < 0 ? span_t'(-diff_x) : span_t'(diff_x)) <= span_x_reg) &&
            ((diff_y < 0 ? span_t'(-diff_y) : span_t'(diff_y)) <= span_y_reg))
        else $error("walk left the line's bounding box");

    // the spare microcode step is never reached
    a_no_spare: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg != STEP_SPARE)
        else $error("sequencer reached spare step");

endmodule

`default_nettype wire
